/* rtl/core/isff_pkg.sv */
// Shared types, register indexes and reset values for the stuffing framer.
`timescale 1ns / 1ps

package isff_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegFlag    = 3'd0;
  localparam logic [2:0] RegEscape  = 3'd1;
  localparam logic [2:0] RegMask    = 3'd2;
  localparam logic [2:0] RegAddress = 3'd3;
  localparam logic [2:0] RegCtlZero = 3'd4;
  localparam logic [2:0] RegCtlOne  = 3'd5;

  localparam logic [7:0] FlagReset    = 8'd126;
  localparam logic [7:0] EscapeReset  = 8'd125;
  localparam logic [7:0] MaskReset    = 8'd32;
  localparam logic [7:0] AddressReset = 8'd3;
  localparam logic [7:0] CtlZeroReset = 8'd0;
  localparam logic [7:0] CtlOneReset  = 8'd64;

  // Depth of the job queue between front and back
  localparam int unsigned JobDepth = 4;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] mask;
    logic [7:0] address;
    logic [7:0] ctl_zero;
    logic [7:0] ctl_one;
  } cfg_t;

  // One classified request: raw byte, updated check and frame marks
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] check;
    logic       seq;
    logic       first;
    logic       last;
  } job_t;

endpackage

/* rtl/core/info_frame_stuffing_framer_top.sv */
// Top level of the information frame byte-stuffing framer.
`timescale 1ns / 1ps

// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// input     | push_i / full_o      | data_byte_i, seq_bit_i, first_byte_i,
//           |                      | last_byte_i
// result    | pop_i / empty_o      | out_byte_o, run_last_o, frame_end_o
// config    | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// The back sequencer emits one output byte per cycle while a job is queued and
// the result side is not stalled. A request yields 1 byte for a plain payload
// byte, 2 for a stuffed one, up to 9 for a one-byte frame (header, stuffed
// byte, stuffed check, closing flag).
// Reset clears the check byte, the queue and the sequencer and loads the
// register defaults; no clearing pass is needed.
// The job queue lets the front keep taking requests while the result side
// stalls; full_o rises only when the queue is full.

module info_frame_stuffing_framer_top #(
  parameter int unsigned JobDepth = isff_pkg::JobDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input requests
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] data_byte_i,
  input  logic       seq_bit_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  // Results
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o,
  // Configuration writes
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);
  import isff_pkg::*;

  cfg_t cfg_q;
  job_t front_job, head_job;
  logic q_push, q_full, q_valid, q_pop;

  // Hold the register file; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag     <= FlagReset;
      cfg_q.escape   <= EscapeReset;
      cfg_q.mask     <= MaskReset;
      cfg_q.address  <= AddressReset;
      cfg_q.ctl_zero <= CtlZeroReset;
      cfg_q.ctl_one  <= CtlOneReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFlag:    cfg_q.flag     <= cfg_wdata_i;
        RegEscape:  cfg_q.escape   <= cfg_wdata_i;
        RegMask:    cfg_q.mask     <= cfg_wdata_i;
        RegAddress: cfg_q.address  <= cfg_wdata_i;
        RegCtlZero: cfg_q.ctl_zero <= cfg_wdata_i;
        RegCtlOne:  cfg_q.ctl_one  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front: accept the request and advance the running check
  isff_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .q_full_i     (q_full),
    .data_byte_i  (data_byte_i),
    .seq_bit_i    (seq_bit_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .q_push_o     (q_push),
    .q_job_o      (front_job)
  );

  isff_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (head_job)
  );

  // Back: expand the job at the queue head into output bytes
  isff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

  assign full_o = q_full;

endmodule

/* rtl/core/isff_fifo.sv */
// Small job queue between the framer front and back.
`timescale 1ns / 1ps

module isff_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  isff_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output isff_pkg::job_t rdata_o
);
  import isff_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthC  = CW'(Depth);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == DepthC);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("job queue count above depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full job queue");
`endif

endmodule

/* rtl/core/isff_front.sv */
// Framer front: accepts payload bytes and keeps the running check byte.
`timescale 1ns / 1ps

module isff_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           q_full_i,
  input  logic [7:0]     data_byte_i,
  input  logic           seq_bit_i,
  input  logic           first_byte_i,
  input  logic           last_byte_i,
  output logic           q_push_o,
  output isff_pkg::job_t q_job_o
);
  import isff_pkg::*;

  logic [7:0] check_q, check_d;

  // Load on a first byte, fold in otherwise
  assign check_d  = first_byte_i ? data_byte_i : (check_q ^ data_byte_i);
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    q_job_o.data  = data_byte_i;
    q_job_o.check = check_d;
    q_job_o.seq   = seq_bit_i;
    q_job_o.first = first_byte_i;
    q_job_o.last  = last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= '0;
    end else if (q_push_o) begin
      check_q <= check_d;
    end
  end

endmodule

/* rtl/core/isff_back.sv */
// Framer back: expands each job into stuffed data, with a header on a first byte and a trailer on a last.
`timescale 1ns / 1ps

module isff_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  isff_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  input  isff_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           frame_end_o
);
  import isff_pkg::*;

  typedef enum logic [3:0] {
    ST_BEGIN,
    ST_FLAG,
    ST_ADDR,
    ST_CTL,
    ST_HCHK,
    ST_DATA,
    ST_DATA2,
    ST_CHK,
    ST_CHK2,
    ST_CLOSE
  } step_e;

  step_e      step_q, cur_step, nxt_step;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q, frame_end_q;
  logic       adv, done, end_flag;
  logic [7:0] emit_byte, ctl;
  logic       data_esc, chk_esc;

  assign ctl      = job_i.seq ? cfg_i.ctl_one : cfg_i.ctl_zero;
  assign data_esc = (job_i.data == cfg_i.flag) || (job_i.data == cfg_i.escape);
  assign chk_esc  = (job_i.check == cfg_i.flag) || (job_i.check == cfg_i.escape);
  assign adv      = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = adv && done;

  always_comb begin
    cur_step = step_q;
    if (step_q == ST_BEGIN) begin
      cur_step = job_i.first ? ST_FLAG : ST_DATA;
    end
    emit_byte = cfg_i.flag;
    nxt_step  = ST_BEGIN;
    done      = 1'b0;
    end_flag  = 1'b0;
    case (cur_step)
      ST_FLAG: begin
        emit_byte = cfg_i.flag;
        nxt_step  = ST_ADDR;
      end
      ST_ADDR: begin
        emit_byte = cfg_i.address;
        nxt_step  = ST_CTL;
      end
      ST_CTL: begin
        emit_byte = ctl;
        nxt_step  = ST_HCHK;
      end
      ST_HCHK: begin
        emit_byte = cfg_i.address ^ ctl;
        nxt_step  = ST_DATA;
      end
      ST_DATA: begin
        if (data_esc) begin
          emit_byte = cfg_i.escape;
          nxt_step  = ST_DATA2;
        end else begin
          emit_byte = job_i.data;
          nxt_step  = job_i.last ? ST_CHK : ST_BEGIN;
          done      = !job_i.last;
        end
      end
      ST_DATA2: begin
        emit_byte = job_i.data ^ cfg_i.mask;
        nxt_step  = job_i.last ? ST_CHK : ST_BEGIN;
        done      = !job_i.last;
      end
      ST_CHK: begin
        if (chk_esc) begin
          emit_byte = cfg_i.escape;
          nxt_step  = ST_CHK2;
        end else begin
          emit_byte = job_i.check;
          nxt_step  = ST_CLOSE;
        end
      end
      ST_CHK2: begin
        emit_byte = job_i.check ^ cfg_i.mask;
        nxt_step  = ST_CLOSE;
      end
      ST_CLOSE: begin
        emit_byte = cfg_i.flag;
        end_flag  = 1'b1;
        done      = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_BEGIN;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      step_q      <= done ? ST_BEGIN : nxt_step;
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q  <= emit_byte;
      run_last_q  <= done;
      frame_end_q <= end_flag;
    end
  end

  assign empty_o     = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && frame_end_q) |-> run_last_q)
    else $error("closing flag not marked as last of its request");
  a_step_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_BEGIN) |-> job_valid_i)
    else $error("sequencer mid-job with no job at queue head");
  a_pop_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (step_q == ST_BEGIN))
    else $error("sequencer not reset after job retired");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the information frame stuffing framer.
`timescale 1ns / 1ps

module tb;
  import isff_pkg::*;

  // Idle cycles after the last byte before the block counts as quiet
  localparam int DrainCycles = 12;

  // One byte of the framed output stream as the block should present it
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } frame_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push_i;
  logic       full_o;
  logic [7:0] data_byte_i;
  logic       seq_bit_i;
  logic       first_byte_i;
  logic       last_byte_i;
  logic       empty_o;
  logic       pop_i;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       frame_end_o;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  // Bytes still owed by the block, oldest first
  frame_byte_t framed_bytes_q[$];
  // Shadow of the register file and of the running payload XOR
  cfg_t        shadow_cfg = {FlagReset, EscapeReset, MaskReset,
                             AddressReset, CtlZeroReset, CtlOneReset};
  logic [7:0]  frame_check = 8'h00;

  int mismatch_count  = 0;
  int tx_idle_pct     = 30;
  int rx_idle_pct     = 30;
  int hold_off_cycles = 0;

  info_frame_stuffing_framer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .data_byte_i  (data_byte_i),
    .seq_bit_i    (seq_bit_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #30_000_000;
    $display("tb: errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Lean on the values that trigger escaping
  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return shadow_cfg.flag;
    if (r < 35) return shadow_cfg.escape;
    return 8'($urandom_range(0, 255));
  endfunction

  // Work out the bytes one accepted request yields and queue them
  function automatic void frame_and_stuff(input logic [7:0] d, input logic s,
                                          input logic f, input logic l);
    logic [7:0]  ctl;
    logic [7:0]  b;
    logic [7:0]  stream[$];
    frame_byte_t e;
    int          i;
    if (f) begin
      ctl = s ? shadow_cfg.ctl_one : shadow_cfg.ctl_zero;
      // header goes out raw, never stuffed
      stream.push_back(shadow_cfg.flag);
      stream.push_back(shadow_cfg.address);
      stream.push_back(ctl);
      stream.push_back(shadow_cfg.address ^ ctl);
      frame_check = d;
    end else begin
      frame_check = frame_check ^ d;
    end
    // stuff the payload byte, then the check byte on a last request
    for (i = 0; i < (l ? 2 : 1); i++) begin
      b = (i == 0) ? d : frame_check;
      if (b == shadow_cfg.flag || b == shadow_cfg.escape) begin
        stream.push_back(shadow_cfg.escape);
        stream.push_back(b ^ shadow_cfg.mask);
      end else begin
        stream.push_back(b);
      end
    end
    if (l) stream.push_back(shadow_cfg.flag);
    for (i = 0; i < stream.size(); i++) begin
      e.out_byte  = stream[i];
      e.run_last  = (i == stream.size() - 1);
      e.frame_end = l && (i == stream.size() - 1);
      framed_bytes_q.push_back(e);
    end
  endfunction

  // Now and then drop push for a random gap, scrambling the payload while idle
  task automatic tx_pause();
    int n;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      n = pick_gap();
      push_i       <= 1'b0;
      data_byte_i  <= 8'($urandom_range(0, 255));
      seq_bit_i    <= 1'($urandom_range(0, 1));
      first_byte_i <= 1'($urandom_range(0, 1));
      last_byte_i  <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Offer one request, hold it until taken, then predict its bytes
  task automatic send_request(input logic [7:0] d, input logic s,
                              input logic f, input logic l);
    push_i       <= 1'b1;
    data_byte_i  <= d;
    seq_bit_i    <= s;
    first_byte_i <= f;
    last_byte_i  <= l;
    do @(posedge clk_i); while (full_o);
    frame_and_stuff(d, s, f, l);
    tx_pause();
  endtask

  // Stop sending and wait for every owed byte plus a quiet stretch
  task automatic wait_idle();
    push_i <= 1'b0;
    while (framed_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      RegFlag:    shadow_cfg.flag     = v;
      RegEscape:  shadow_cfg.escape   = v;
      RegMask:    shadow_cfg.mask     = v;
      RegAddress: shadow_cfg.address  = v;
      RegCtlZero: shadow_cfg.ctl_zero = v;
      RegCtlOne:  shadow_cfg.ctl_one  = v;
      default: ;
    endcase
  endtask

  // Write all six registers back to back; call only while idle
  task automatic apply_config(input cfg_t c);
    write_reg(RegFlag, c.flag);
    write_reg(RegEscape, c.escape);
    write_reg(RegMask, c.mask);
    write_reg(RegAddress, c.address);
    write_reg(RegCtlZero, c.ctl_zero);
    write_reg(RegCtlOne, c.ctl_one);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_defaults();
    // stray bytes before any frame, then a last with no first
    send_request(EscapeReset, 1'b0, 1'b0, 1'b0);
    send_request(FlagReset, 1'b1, 1'b0, 1'b1);
    // one-byte frames: flag and escape values stuffed twice over
    send_request(FlagReset, 1'b0, 1'b1, 1'b1);
    send_request(EscapeReset, 1'b1, 1'b1, 1'b1);
    // frame with the extremes and both special values inside
    send_request(8'h00, 1'b1, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0, 1'b0);
    send_request(EscapeReset, 1'b1, 1'b0, 1'b0);
    send_request(FlagReset, 1'b0, 1'b0, 1'b0);
    send_request(8'h03, 1'b1, 1'b0, 1'b1);
    // check byte lands on the flag, then on the escape
    send_request(8'h70, 1'b0, 1'b1, 1'b0);
    send_request(8'h0E, 1'b0, 1'b0, 1'b1);
    send_request(8'h7C, 1'b1, 1'b1, 1'b0);
    send_request(8'h01, 1'b0, 1'b0, 1'b1);
    // a first while a frame is still open restarts the check
    send_request(8'h11, 1'b1, 1'b1, 1'b0);
    send_request(8'h22, 1'b0, 1'b1, 1'b0);
    send_request(8'h33, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // flag equal to escape: a matching byte is escaped once
    apply_config({8'h55, 8'h55, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    send_request(8'h55, 1'b0, 1'b1, 1'b0);
    send_request(8'hAA, 1'b1, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0, 1'b1);
    send_request(8'h55, 1'b1, 1'b1, 1'b1);
    wait_idle();
    // zero mask: the escaped byte goes out unchanged
    apply_config({8'h00, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01});
    send_request(8'h00, 1'b1, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0, 1'b1);
  endtask

  // Stall the result side long enough that the block refuses requests
  task automatic test_backpressure();
    int i;
    wait_idle();
    tx_idle_pct     = 0;
    hold_off_cycles = 150;
    for (i = 0; i < 20; i++)
      send_request(pick_payload(), 1'($urandom_range(0, 1)), i % 5 == 0, i % 5 == 4);
    wait_idle();
    tx_idle_pct = 30;
  endtask

  task automatic test_random_frames();
    int         phase;
    int         sent;
    int         len;
    int         i;
    logic [7:0] d;
    cfg_t       c;
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      c.flag     = 8'($urandom_range(0, 255));
      c.escape   = ($urandom_range(0, 3) == 0) ? c.flag : 8'($urandom_range(0, 255));
      c.mask     = 8'($urandom_range(0, 255));
      c.address  = 8'($urandom_range(0, 255));
      c.ctl_zero = 8'($urandom_range(0, 255));
      c.ctl_one  = 8'($urandom_range(0, 255));
      apply_config(c);
      case (phase)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 20; rx_idle_pct = 20; end
        2: begin tx_idle_pct = 50; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 10; rx_idle_pct = 60; end
      endcase
      sent = 0;
      while (sent < 50) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: marks in any combination
          send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
          for (i = 0; i < len; i++) begin
            d = pick_payload();
            // steer the check byte onto a value that needs escaping
            if (i == len - 1 && i != 0 && $urandom_range(0, 3) == 0)
              d = frame_check ^ ($urandom_range(0, 1) ? shadow_cfg.flag : shadow_cfg.escape);
            send_request(d, 1'($urandom_range(0, 1)), i == 0, i == len - 1);
          end
          sent += len;
        end
      end
    end
    tx_idle_pct = 30;
    rx_idle_pct = 30;
  endtask

  // Result side: random pop gaps, plus a long hold-off on request
  initial begin : drive_pop
    int n;
    pop_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        pop_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        n = pick_gap();
        pop_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // Compare every popped byte with the oldest owed one
  always @(posedge clk_i) begin : check_bytes
    frame_byte_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (framed_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte %02h run_last %b frame_end %b", $time,
                 out_byte_o, run_last_o, frame_end_o);
        mismatch_count++;
      end else begin
        want = framed_bytes_q.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $display("%0t: out_byte expected %02h got %02h", $time,
                   want.out_byte, out_byte_o);
          mismatch_count++;
        end
        if (run_last_o !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time,
                   want.run_last, run_last_o);
          mismatch_count++;
        end
        if (frame_end_o !== want.frame_end) begin
          $display("%0t: frame_end expected %b got %b", $time,
                   want.frame_end, frame_end_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : run_tests
    rst_ni       <= 1'b0;
    push_i       <= 1'b0;
    data_byte_i  <= 8'h00;
    seq_bit_i    <= 1'b0;
    first_byte_i <= 1'b0;
    last_byte_i  <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= RegFlag;
    cfg_wdata_i  <= 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_frames();
    wait_idle();

    if (mismatch_count == 0 && framed_bytes_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
